[sv/bblur_pkg.sv]
// Shared constants, codes and types of the 3x3 border-clipped box blur.
`default_nettype none

package bblur_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W = 8;
    localparam int FW_W  = 12;
    localparam int FH_W  = 16;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CSUM_W      = 10;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_6 = 13'd5462;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd3641;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    typedef struct packed {
        logic wr;
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
    } ctrl_t;

endpackage

`default_nettype wire

[sv/bblur_front.sv]
// Front end: accepts requests, tracks frame positions and classifies each request.
`default_nettype none

module bblur_front #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr,
    input  wire logic [bblur_pkg::FW_W-1:0]        frame_width,
    input  wire logic [bblur_pkg::FH_W-1:0]        frame_height,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_cmd,
    input  wire logic [bblur_pkg::PIX_W-1:0]       s_pixel_value,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]           push_addr,
    output logic [bblur_pkg::PIX_W-1:0]            push_pix,
    output bblur_pkg::ctrl_t                       push_ctrl
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [AW-1:0]              in_col_reg, in_col_next;
    logic [bblur_pkg::FH_W-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]              out_col_reg, out_col_next;
    logic [bblur_pkg::FH_W-1:0] out_row_reg, out_row_next;
    logic [PW-1:0]              pend_reg, pend_next;

    logic [WW-1:0]              w_eff, w_last;
    logic [bblur_pkg::FH_W-1:0] h_eff, h_last;
    logic                       at_start, pend_full, pend_zero, is_drain;
    logic                       restart, drain_go, enq, acc;
    logic                       out_col_end, out_row_end;
    logic [AW-1:0]              vc;

    always_comb begin
        if (frame_width < 12'd2) begin
            w_eff = WW'(2);
        end else if (32'(frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width);
        end
        h_eff  = (frame_height < 16'd2) ? 16'd2 : frame_height;
        w_last = w_eff - WW'(1);
        h_last = h_eff - 16'd1;
    end

    assign at_start    = (in_col_reg == '0) && (in_row_reg == '0);
    assign pend_full   = (pend_reg == (PW'(w_eff) + PW'(1)));
    assign pend_zero   = (pend_reg == '0);
    assign is_drain    = (s_cmd == bblur_pkg::CMD_DRAIN);
    assign restart     = !is_drain && at_start && !pend_full;
    assign drain_go    = is_drain && at_start && !pend_zero;
    assign enq         = !is_drain || drain_go;
    assign out_col_end = (WW'(out_col_reg) == w_last);
    assign out_row_end = (out_row_reg == h_last);
    assign vc          = out_col_end ? '0 : out_col_reg + AW'(1);

    assign s_ready    = push_ready;
    assign acc        = s_valid && s_ready;
    assign push_valid = s_valid && enq;
    assign push_addr  = is_drain ? vc : in_col_reg;
    assign push_pix   = is_drain ? '0 : s_pixel_value;

    always_comb begin
        push_ctrl.wr        = !is_drain;
        push_ctrl.emit      = is_drain ? drain_go : pend_full;
        push_ctrl.top_ok    = (out_row_reg != '0);
        push_ctrl.bot_ok    = !out_row_end;
        push_ctrl.left_ok   = (out_col_reg != '0);
        push_ctrl.right_ok  = !out_col_end;
        push_ctrl.frame_end = out_row_end && out_col_end;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (cfg_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end else if (acc) begin
            if (!is_drain) begin
                if (WW'(in_col_reg) == w_last) begin
                    in_col_next = '0;
                    in_row_next = (in_row_reg == h_last) ? '0 : in_row_reg + 16'd1;
                end else begin
                    in_col_next = in_col_reg + AW'(1);
                end
            end
            if (restart) begin
                out_col_next = '0;
                out_row_next = '0;
                pend_next    = PW'(1);
            end else if ((!is_drain && pend_full) || drain_go) begin
                if (out_col_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_end ? '0 : out_row_reg + 16'd1;
                end else begin
                    out_col_next = out_col_reg + AW'(1);
                end
                if (drain_go) begin
                    pend_next = pend_reg - PW'(1);
                end
            end else if (!is_drain) begin
                pend_next = pend_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

`default_nettype wire

[sv/bblur_queue.sv]
// Short request queue between the front end and the back end.
`default_nettype none

module bblur_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = bblur_pkg::QUEUE_AW;
    localparam int CW = bblur_pkg::QUEUE_AW + 1;

    logic [WIDTH-1:0] store_reg [bblur_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(bblur_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(bblur_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(bblur_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/bblur_back.sv]
// Back end: line memories, 3x3 window, clipped sum and divide pipeline.
`default_nettype none

module bblur_back #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
    input  wire logic [bblur_pkg::PIX_W-1:0]   q_pix,
    input  wire bblur_pkg::ctrl_t              q_ctrl,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bblur_pkg::PIX_W-1:0]        m_out_pixel,
    output logic                               m_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = bblur_pkg::PIX_W;
    localparam int CS = bblur_pkg::CSUM_W;
    localparam int SW = bblur_pkg::SUM_W;
    localparam int MW = bblur_pkg::SUM_W + bblur_pkg::RECIP_W;

    logic [PW-1:0] line_a [MAX_WIDTH];
    logic [PW-1:0] line_b [MAX_WIDTH];
    logic [PW-1:0] taps_reg [9];

    logic                 s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    bblur_pkg::ctrl_t     s2_ctrl_reg, s3_ctrl_reg, s4_ctrl_reg;
    logic [AW-1:0]        s2_addr_reg;
    logic [PW-1:0]        s2_pix_reg, rd_a_reg, rd_b_reg;
    logic [CS-1:0]        cs0_reg, cs1_reg, cs2_reg;
    logic [SW-1:0]        sum_reg;
    bblur_pkg::div_sel_t  div_sel_reg, div_sel;
    bblur_pkg::div_sel_t  s5_div_sel_reg;
    logic                 s5_frame_end_reg;
    logic                 m_valid_reg, m_frame_end_reg;
    logic [PW-1:0]        m_out_pixel_reg;

    logic                 pop, s2_adv, s2_ready, s3_go, s3_ready, s4_load;
    logic                 s4_go, s4_ready, s5_go, s5_ready, s6_ready;
    logic                 rows_full, cols_full;
    logic [CS-1:0]        csum [3];
    logic [SW-1:0]        total;
    logic [bblur_pkg::RECIP_W-1:0] recip;
    logic [MW-1:0]        prod;
    logic [PW-1:0]        quo;

    assign s6_ready = !m_valid_reg || m_ready;
    assign s5_go    = s5_valid_reg && s6_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_go    = s4_valid_reg && s5_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_go    = s3_valid_reg && (!s3_ctrl_reg.emit || s4_ready);
    assign s3_ready = !s3_valid_reg || s3_go;
    assign s4_load  = s3_go && s3_ctrl_reg.emit;
    assign s2_adv   = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s2_adv;
    assign q_ready  = s2_ready;
    assign pop      = q_valid && s2_ready;

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_a_reg <= line_a[q_addr];
            rd_b_reg <= line_b[q_addr];
            if (q_ctrl.wr) begin
                line_a[q_addr] <= q_pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s2_ctrl_reg.wr) begin
            line_b[s2_addr_reg] <= rd_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            for (int i = 0; i < 6; i++) begin
                taps_reg[i] <= taps_reg[i+3];
            end
            taps_reg[6] <= rd_b_reg;
            taps_reg[7] <= rd_a_reg;
            taps_reg[8] <= s2_pix_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            csum[c] = (s3_ctrl_reg.top_ok ? CS'(taps_reg[3*c]) : '0)
                    + CS'(taps_reg[3*c+1])
                    + (s3_ctrl_reg.bot_ok ? CS'(taps_reg[3*c+2]) : '0);
        end
        rows_full = s3_ctrl_reg.top_ok && s3_ctrl_reg.bot_ok;
        cols_full = s3_ctrl_reg.left_ok && s3_ctrl_reg.right_ok;
        if (rows_full && cols_full) begin
            div_sel = bblur_pkg::DIV_BY_9;
        end else if (!rows_full && !cols_full) begin
            div_sel = bblur_pkg::DIV_BY_4;
        end else begin
            div_sel = bblur_pkg::DIV_BY_6;
        end
    end

    assign total = (s4_ctrl_reg.left_ok ? SW'(cs0_reg) : '0)
                 + SW'(cs1_reg)
                 + (s4_ctrl_reg.right_ok ? SW'(cs2_reg) : '0);

    always_comb begin
        case (s5_div_sel_reg)
            bblur_pkg::DIV_BY_9: recip = bblur_pkg::RECIP_9;
            default:             recip = bblur_pkg::RECIP_6;
        endcase
        prod = MW'(sum_reg) * MW'(recip);
        case (s5_div_sel_reg)
            bblur_pkg::DIV_BY_4: quo = PW'(sum_reg >> 2);
            default:             quo = PW'(prod >> bblur_pkg::RECIP_SHIFT);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                s3_valid_reg <= 1'b1;
            end else if (s3_go) begin
                s3_valid_reg <= 1'b0;
            end
            if (s4_load) begin
                s4_valid_reg <= 1'b1;
            end else if (s4_go) begin
                s4_valid_reg <= 1'b0;
            end
            if (s4_go) begin
                s5_valid_reg <= 1'b1;
            end else if (s5_go) begin
                s5_valid_reg <= 1'b0;
            end
            if (s5_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s2_ctrl_reg <= q_ctrl;
            s2_addr_reg <= q_addr;
            s2_pix_reg  <= q_pix;
        end
        if (s2_adv) begin
            s3_ctrl_reg <= s2_ctrl_reg;
        end
        if (s4_load) begin
            s4_ctrl_reg <= s3_ctrl_reg;
            cs0_reg     <= csum[0];
            cs1_reg     <= csum[1];
            cs2_reg     <= csum[2];
            div_sel_reg <= div_sel;
        end
        if (s4_go) begin
            sum_reg          <= total;
            s5_div_sel_reg   <= div_sel_reg;
            s5_frame_end_reg <= s4_ctrl_reg.frame_end;
        end
        if (s5_go) begin
            m_out_pixel_reg <= quo;
            m_frame_end_reg <= s5_frame_end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_pixel = m_out_pixel_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

`default_nettype wire

[sv/box_blur_3x3_border_average.sv]
// Path to a result: queue, line read, window, column sums, sum and divide registers.
// Each result leaves with the request one row plus one pixel later, or with a drain.
// Throughput: one request per cycle unless the output stalls, set by the one read and
// one write per cycle on each line memory.
// Reset: positions cleared, size registers 640 x 480; line memories keep old contents,
// which always fall outside the current frame and are clipped away.
`default_nettype none

module box_blur_3x3_border_average #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bblur_pkg::APB_AW-1:0]    paddr,
    input  wire logic [bblur_pkg::APB_DW-1:0]    pwdata,
    output logic [bblur_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_cmd,
    input  wire logic [bblur_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bblur_pkg::PIX_W-1:0]          m_out_pixel,
    output logic                                 m_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = AW + bblur_pkg::PIX_W + $bits(bblur_pkg::ctrl_t);

    logic [bblur_pkg::FW_W-1:0] frame_width_reg;
    logic [bblur_pkg::FH_W-1:0] frame_height_reg;
    logic                       cfg_wr, reg_idx;

    logic                       push_valid, push_ready, pop_valid, pop_ready;
    logic [AW-1:0]              push_addr, pop_addr;
    logic [bblur_pkg::PIX_W-1:0] push_pix, pop_pix;
    bblur_pkg::ctrl_t           push_ctrl, pop_ctrl;
    logic [QW-1:0]              push_data, pop_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bblur_pkg::APB_AW-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            bblur_pkg::REG_FRAME_WIDTH:  prdata = bblur_pkg::APB_DW'(frame_width_reg);
            bblur_pkg::REG_FRAME_HEIGHT: prdata = bblur_pkg::APB_DW'(frame_height_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bblur_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bblur_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bblur_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= pwdata[bblur_pkg::FW_W-1:0];
                bblur_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[bblur_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pixel_value (s_pixel_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_addr     (push_addr),
        .push_pix      (push_pix),
        .push_ctrl     (push_ctrl)
    );

    assign push_data = {push_addr, push_pix, push_ctrl};
    assign {pop_addr, pop_pix, pop_ctrl} = pop_data;

    bblur_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bblur_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_addr      (pop_addr),
        .q_pix       (pop_pix),
        .q_ctrl      (pop_ctrl),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire

[test/box_blur_3x3_border_average_test.sv]
// Self-checking testbench for the 3x3 border-clipped box blur.
`timescale 1ns / 1ps

module box_blur_3x3_border_average_test;
    import bblur_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int ITEM_BUDGET    = 1750;
    localparam int DRAIN_SLACK    = 24;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        bit              cmd;
        bit [PIX_W-1:0]  pix;
    } blur_req_t;

    typedef struct {
        bit [PIX_W-1:0]  pix;
        bit              fend;
    } blur_px_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_cmd         = CMD_PIXEL;
    logic [PIX_W-1:0]   s_pixel_value = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [PIX_W-1:0]   m_out_pixel;
    logic               m_frame_end;

    blur_req_t          feed_q[$];
    blur_px_t           blur_want_q[$];
    logic               req_taken     = 1'b0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        fed_count     = 0;
    int unsigned        err_count     = 0;
    int unsigned        quiet_cycles  = 0;

    // predictor state
    bit [PIX_W-1:0]     line_new [MAX_W];
    bit [PIX_W-1:0]     line_old [MAX_W];
    bit [PIX_W-1:0]     win_taps [9];
    int unsigned        in_x = 0, in_y = 0, out_x = 0, out_y = 0;
    int unsigned        size_w_reg = FRAME_WIDTH_RST;
    int unsigned        size_h_reg = FRAME_HEIGHT_RST;

    box_blur_3x3_border_average u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_pixel   (m_out_pixel),
        .m_frame_end   (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned frame_w(int unsigned r);
        return (r < 2) ? 2 : ((r > MAX_W) ? MAX_W : r);
    endfunction

    function automatic int unsigned frame_h(int unsigned r);
        return (r < 2) ? 2 : r;
    endfunction

    function automatic void win_shift(bit [PIX_W-1:0] top, bit [PIX_W-1:0] mid,
                                      bit [PIX_W-1:0] bot);
        for (int i = 0; i < 6; i++)
            win_taps[i] = win_taps[i + 3];
        win_taps[6] = top;
        win_taps[7] = mid;
        win_taps[8] = bot;
    endfunction

    function automatic void blur_emit(int unsigned w, int unsigned h);
        int unsigned r_lo, r_hi, c_lo, c_hi, acc, n;
        blur_px_t    px;
        r_lo = (out_y > 0) ? 0 : 1;
        r_hi = (out_y + 1 < h) ? 2 : 1;
        c_lo = (out_x > 0) ? 0 : 1;
        c_hi = (out_x + 1 < w) ? 2 : 1;
        acc  = 0;
        for (int unsigned c = c_lo; c <= c_hi; c++)
            for (int unsigned r = r_lo; r <= r_hi; r++)
                acc += win_taps[3 * c + r];
        n       = (r_hi - r_lo + 1) * (c_hi - c_lo + 1);
        px.pix  = PIX_W'(acc / n);
        px.fend = (out_y == h - 1) && (out_x == w - 1);
        blur_want_q.push_back(px);
        out_x++;
        if (out_x >= w) begin
            out_x = 0;
            out_y++;
            if (out_y >= h) out_y = 0;
        end
    endfunction

    function automatic void blur_predict(bit cmd, bit [PIX_W-1:0] pix);
        int unsigned       w, h, c, vc;
        longint unsigned   ip, op, pend;
        bit                at_start;
        bit [PIX_W-1:0]    oa, ob;
        w  = frame_w(size_w_reg);
        h  = frame_h(size_h_reg);
        ip = longint'(in_y) * w + in_x;
        op = longint'(out_y) * w + out_x;
        pend = (ip >= op) ? ip - op : ip + longint'(w) * h - op;
        at_start = (in_y == 0) && (in_x == 0);
        if (cmd == CMD_PIXEL) begin
            // restart the output side unless the previous frame tail is whole
            if (at_start && pend != w + 1) begin
                out_x = 0;
                out_y = 0;
                pend  = 0;
            end
            c  = (in_x >= MAX_W) ? MAX_W - 1 : in_x;
            oa = line_new[c];
            ob = line_old[c];
            line_old[c] = oa;
            line_new[c] = pix;
            win_shift(ob, oa, pix);
            in_x++;
            if (in_x >= w) begin
                in_x = 0;
                in_y++;
                if (in_y >= h) in_y = 0;
            end
            if (pend >= w + 1) blur_emit(w, h);
        end else if (at_start && pend != 0) begin
            vc = (out_x + 1 >= w) ? 0 : out_x + 1;
            if (vc >= MAX_W) vc = 0;
            win_shift(line_old[vc], line_new[vc], '0);
            blur_emit(w, h);
        end
    endfunction

    function automatic bit [PIX_W-1:0] any_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_item(bit cmd, bit [PIX_W-1:0] pix);
        feed_q.push_back('{cmd: cmd, pix: pix});
    endtask

    task automatic feed_pixels(int unsigned n, bit noisy);
        for (int unsigned i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 31) == 0) push_item(CMD_DRAIN, any_pixel());
            push_item(CMD_PIXEL, any_pixel());
        end
        fed_count += n;
    endtask

    task automatic push_drains(int unsigned n);
        repeat (n) push_item(CMD_DRAIN, any_pixel());
        fed_count += n;
    endtask

    task automatic settle();
        while (feed_q.size() != 0 || s_valid || blur_want_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic apb_size_write(logic idx, int unsigned val);
        bit [APB_DW-1:0] junk;
        junk = $urandom();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        if (idx == REG_FRAME_WIDTH) pwdata <= {junk[APB_DW-1:FW_W], FW_W'(val)};
        else pwdata <= {junk[APB_DW-1:FH_W], FH_W'(val)};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid       <= 1'b1;
                s_cmd         <= feed_q[0].cmd;
                s_pixel_value <= feed_q[0].pix;
                void'(feed_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (blur_want_q.size() == 0) begin
                    $error("out_pixel: expected none, actual %0d", m_out_pixel);
                    err_count++;
                end else begin
                    if (m_out_pixel !== blur_want_q[0].pix) begin
                        $error("out_pixel: expected %0d, actual %0d",
                               blur_want_q[0].pix, m_out_pixel);
                        err_count++;
                    end
                    if (m_frame_end !== blur_want_q[0].fend) begin
                        $error("frame_end: expected %0d, actual %0d",
                               blur_want_q[0].fend, m_frame_end);
                        err_count++;
                    end
                    void'(blur_want_q.pop_front());
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_FRAME_WIDTH) size_w_reg = pwdata[FW_W-1:0];
                else size_h_reg = pwdata[FH_W-1:0];
                in_x  = 0;
                in_y  = 0;
                out_x = 0;
                out_y = 0;
            end
            if (s_valid && s_ready) blur_predict(s_cmd, s_pixel_value);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned cur_wr, cur_hr, wr, hr, w, h, kind;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // default 640x480: drain with nothing pending, drain in mid frame
        push_item(CMD_DRAIN, 8'hA5);
        push_item(CMD_PIXEL, 8'hFF);
        push_item(CMD_PIXEL, 8'h00);
        push_item(CMD_DRAIN, 8'h5A);
        push_item(CMD_PIXEL, 8'h80);
        settle();

        // out-of-range sizes clamp to a 2x2 frame
        cur_wr = 0;
        cur_hr = 1;
        apb_size_write(REG_FRAME_WIDTH, cur_wr);
        apb_size_write(REG_FRAME_HEIGHT, cur_hr);
        repeat (4) push_item(CMD_PIXEL, 8'hFF);
        // back-to-back frame flushes the previous tail
        push_item(CMD_PIXEL, 8'h00);
        push_item(CMD_PIXEL, 8'hFF);
        push_item(CMD_PIXEL, 8'h00);
        push_item(CMD_PIXEL, 8'hFF);
        // partial flush, then a new frame drops the rest
        push_item(CMD_DRAIN, 8'h00);
        push_item(CMD_DRAIN, 8'hFF);
        push_item(CMD_PIXEL, 8'hFF);
        push_item(CMD_PIXEL, 8'h00);
        push_item(CMD_PIXEL, 8'hFF);
        push_item(CMD_PIXEL, 8'hFF);
        repeat (4) push_item(CMD_DRAIN, 8'h3C);

        fed_count = 0;
        while (fed_count < ITEM_BUDGET) begin
            if (fed_count < ITEM_BUDGET / 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 75;
            end else if (fed_count < 2 * ITEM_BUDGET / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            kind = $urandom_range(0, 9);
            wr   = $urandom_range(2, 12);
            hr   = $urandom_range(2, 6);
            case (kind)
                0: wr = $urandom_range(0, 1);
                1: hr = $urandom_range(0, 1);
                2: begin
                    wr = $urandom_range(13, 40);
                    hr = $urandom_range(2, 3);
                end
                3: hr = 16'hFFFF;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    cur_wr = wr;
                    apb_size_write(REG_FRAME_WIDTH, cur_wr);
                end
                1: begin
                    cur_hr = hr;
                    apb_size_write(REG_FRAME_HEIGHT, cur_hr);
                end
                default: begin
                    cur_wr = wr;
                    cur_hr = hr;
                    apb_size_write(REG_FRAME_WIDTH, cur_wr);
                    apb_size_write(REG_FRAME_HEIGHT, cur_hr);
                end
            endcase
            w = frame_w(cur_wr);
            h = frame_h(cur_hr);
            if (h > 64) begin
                // tall frame: stream a few rows, drains land mid frame
                feed_pixels(w * $urandom_range(2, 5) + $urandom_range(0, w - 1), 1);
                push_drains($urandom_range(1, 3));
            end else begin
                repeat ($urandom_range(1, 3)) feed_pixels(w * h, 1);
                case ($urandom_range(0, 5))
                    0: begin
                        push_drains($urandom_range(1, w));
                        feed_pixels(w * h, 0);
                        push_drains(w + 1 + $urandom_range(0, 2));
                    end
                    1: feed_pixels($urandom_range(1, w * h - 1), 1);
                    2: ;
                    default: push_drains(w + 1 + $urandom_range(0, 2));
                endcase
            end
        end

        // widest row: width register all ones, tallest height, partial frame
        settle();
        cur_wr = 12'hFFF;
        cur_hr = 16'hFFFF;
        apb_size_write(REG_FRAME_WIDTH, cur_wr);
        apb_size_write(REG_FRAME_HEIGHT, cur_hr);
        feed_pixels(frame_w(cur_wr) + 41, 0);

        settle();
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[box_blur_3x3_border_average.f]
sv/bblur_pkg.sv
sv/bblur_front.sv
sv/bblur_queue.sv
sv/bblur_back.sv
sv/box_blur_3x3_border_average.sv
test/box_blur_3x3_border_average_test.sv
